@@ rtl/nnsa_pkg.sv @@
`timescale 1ns / 1ps

package nnsa_pkg;

  // Widths of the register file and of the beat fields.
  localparam int APB_DATA_W  = 32;
  localparam int PADDR_W     = 5;
  localparam int SRC_REG_W   = 9;
  localparam int PANEL_REG_W = 8;
  localparam int REGION_W    = 9;
  localparam int COORD_W     = 7;
  localparam int ADDR_W      = 18;
  localparam int S_TDATA_W   = 16;
  localparam int M_TDATA_W   = 32;

  // Each source pixel occupies three bytes (red, green, blue).
  localparam int unsigned BYTES_PER_PIXEL = 3;

  // Register indexes, one 32-bit word apart on the configuration port.
  typedef enum logic [2:0] {
    REG_SRC_WIDTH    = 3'd0,
    REG_SRC_HEIGHT   = 3'd1,
    REG_PANEL_WIDTH  = 3'd2,
    REG_PANEL_HEIGHT = 3'd3,
    REG_REGION_START = 3'd4,
    REG_REGION_END   = 3'd5
  } reg_idx_t;

  // Values after reset.
  localparam logic [SRC_REG_W-1:0]   SRC_WIDTH_RST    = 9'd64;
  localparam logic [SRC_REG_W-1:0]   SRC_HEIGHT_RST   = 9'd64;
  localparam logic [PANEL_REG_W-1:0] PANEL_WIDTH_RST  = 8'd64;
  localparam logic [PANEL_REG_W-1:0] PANEL_HEIGHT_RST = 8'd64;
  localparam logic [REGION_W-1:0]    REGION_START_RST = 9'd0;
  localparam logic [REGION_W-1:0]    REGION_END_RST   = 9'd64;

endpackage

@@ rtl/nearest_neighbor_scale_addr_core.sv @@
`timescale 1ns / 1ps

// Channel   | Direction | Handshake               | Beat contents (lowest bit first)
// ----------+-----------+-------------------------+-----------------------------------------
// s_        | in        | s_tvalid / s_tready     | dest_dx[6:0], dest_dy[13:7], zero pad
// m_        | out       | m_tvalid / m_tready     | src_byte_addr[17:0], panel_x[24:18],
//           |           |                         | panel_y[31:25]
// APB       | in / out  | psel, penable, pready   | six registers at byte addresses 0..20
//
// One beat is taken in every cycle while the pipeline is not stalled and, when it lies inside the
// region, passes through the capture stage, the divider stages and the index sum stage to the output register.
// The depth of the pipeline is set by the two restoring dividers, which produce one quotient bit a stage.
// A synchronous reset of one cycle restores the registers and empties the pipeline.
// Each stage holds its beat while the stage after it is full and blocked, so a stall
// neither drops nor repeats a beat, and bubbles close up behind a stalled output.

module nearest_neighbor_scale_addr_core #(
  parameter int MAX_SRC_DIM   = 256,
  parameter int MAX_PANEL_DIM = 128
) (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration port.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [nnsa_pkg::PADDR_W-1:0]        paddr,
  input  logic [nnsa_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [nnsa_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  // Destination pixel beats.
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [nnsa_pkg::S_TDATA_W-1:0]      s_tdata,   // dest_dx, dest_dy
  // Source address beats.
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [nnsa_pkg::M_TDATA_W-1:0]      m_tdata    // src_byte_addr, panel_x, panel_y
);

  import nnsa_pkg::*;

  // Source dimensions after saturation need SDW bits, panel dimensions PDW bits.
  localparam int SDW_RAW = $clog2(MAX_SRC_DIM + 1);
  localparam int SDW     = (SDW_RAW < SRC_REG_W) ? SDW_RAW : SRC_REG_W;
  localparam int PDW_RAW = $clog2(MAX_PANEL_DIM + 1);
  localparam int PDW     = (PDW_RAW < PANEL_REG_W) ? PDW_RAW : PANEL_REG_W;
  // The quotient is always below the source dimension, so SDW bits hold it.
  localparam int QW      = SDW;
  localparam int NW      = COORD_W + SDW;
  localparam int SUMW    = 2 * SDW;
  localparam int PRODW   = SUMW + 2;
  localparam int CMPW    = (PDW > COORD_W) ? PDW : COORD_W;
  // Capture stage, QW + 1 divider stages, index sum stage, output register.
  localparam int NST     = QW + 4;
  localparam int SA      = QW + 2;
  localparam int OS      = QW + 3;

  function automatic logic [SDW-1:0] sat_src(input logic [SRC_REG_W-1:0] v);
    if (v == '0) begin
      return SDW'(1);
    end else if (32'(v) > 32'(MAX_SRC_DIM)) begin
      return SDW'(MAX_SRC_DIM);
    end else begin
      return SDW'(v);
    end
  endfunction

  function automatic logic [PDW-1:0] sat_panel(input logic [PANEL_REG_W-1:0] v);
    if (32'(v) > 32'(MAX_PANEL_DIM)) begin
      return PDW'(MAX_PANEL_DIM);
    end else begin
      return PDW'(v);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Register file. Besides the raw registers, the clipped and saturated values
  // that the pipeline needs are kept in registers of their own, worked out from
  // the next register values so that they are ready in the cycle after a write.
  // ---------------------------------------------------------------------------
  logic [SRC_REG_W-1:0]   src_width, src_width_next;
  logic [SRC_REG_W-1:0]   src_height, src_height_next;
  logic [PANEL_REG_W-1:0] panel_width, panel_width_next;
  logic [PANEL_REG_W-1:0] panel_height, panel_height_next;
  logic [REGION_W-1:0]    region_start, region_start_next;
  logic [REGION_W-1:0]    region_end, region_end_next;

  logic [SDW-1:0]         cfg_sw, cfg_sw_next;
  logic [SDW-1:0]         cfg_sh, cfg_sh_next;
  logic [PDW-1:0]         cfg_ph, cfg_ph_next;
  logic [7:0]             cfg_start, cfg_start_next;
  logic [PDW-1:0]         cfg_dw, cfg_dw_next;
  logic                   cfg_empty, cfg_empty_next;

  logic [PDW-1:0]         pw_c;
  logic [PDW-1:0]         end_c;
  logic [REGION_W-1:0]    width_c;

  logic                   cfg_wr;
  logic [2:0]             cfg_idx;

  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[PADDR_W-1:2];
  assign pready  = 1'b1;

  always_comb begin
    src_width_next    = src_width;
    src_height_next   = src_height;
    panel_width_next  = panel_width;
    panel_height_next = panel_height;
    region_start_next = region_start;
    region_end_next   = region_end;
    if (rst) begin
      src_width_next    = SRC_WIDTH_RST;
      src_height_next   = SRC_HEIGHT_RST;
      panel_width_next  = PANEL_WIDTH_RST;
      panel_height_next = PANEL_HEIGHT_RST;
      region_start_next = REGION_START_RST;
      region_end_next   = REGION_END_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SRC_WIDTH:    src_width_next    = pwdata[SRC_REG_W-1:0];
        REG_SRC_HEIGHT:   src_height_next   = pwdata[SRC_REG_W-1:0];
        REG_PANEL_WIDTH:  panel_width_next  = pwdata[PANEL_REG_W-1:0];
        REG_PANEL_HEIGHT: panel_height_next = pwdata[PANEL_REG_W-1:0];
        REG_REGION_START: region_start_next = pwdata[REGION_W-1:0];
        REG_REGION_END:   region_end_next   = pwdata[REGION_W-1:0];
        default: ;
      endcase
    end
  end

  // A negative start (sign bit set) clips to column zero; the end clips to the panel.
  always_comb begin
    cfg_sw_next    = sat_src(src_width_next);
    cfg_sh_next    = sat_src(src_height_next);
    cfg_ph_next    = sat_panel(panel_height_next);
    pw_c           = sat_panel(panel_width_next);
    cfg_start_next = region_start_next[REGION_W-1] ? 8'd0 : region_start_next[7:0];
    if (region_end_next > REGION_W'(pw_c)) begin
      end_c = pw_c;
    end else begin
      end_c = PDW'(region_end_next);
    end
    cfg_empty_next = {1'b0, cfg_start_next} >= REGION_W'(end_c);
    width_c        = REGION_W'(end_c) - {1'b0, cfg_start_next};
    cfg_dw_next    = PDW'(width_c);
  end

  always_ff @(posedge clk) begin
    src_width    <= src_width_next;
    src_height   <= src_height_next;
    panel_width  <= panel_width_next;
    panel_height <= panel_height_next;
    region_start <= region_start_next;
    region_end   <= region_end_next;
    cfg_sw       <= cfg_sw_next;
    cfg_sh       <= cfg_sh_next;
    cfg_ph       <= cfg_ph_next;
    cfg_start    <= cfg_start_next;
    cfg_dw       <= cfg_dw_next;
    cfg_empty    <= cfg_empty_next;
  end

  always_comb begin
    case (cfg_idx)
      REG_SRC_WIDTH:    prdata = APB_DATA_W'(src_width);
      REG_SRC_HEIGHT:   prdata = APB_DATA_W'(src_height);
      REG_PANEL_WIDTH:  prdata = APB_DATA_W'(panel_width);
      REG_PANEL_HEIGHT: prdata = APB_DATA_W'(panel_height);
      REG_REGION_START: prdata = APB_DATA_W'(region_start);
      REG_REGION_END:   prdata = APB_DATA_W'(region_end);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Stage flow. A stage may load when it is empty or when its own beat moves on;
  // the output register moves on when the sink takes it.
  // ---------------------------------------------------------------------------
  logic [NST-1:0] vld;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !vld[NST-1] || m_tready;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign s_tready = en[0];

  // ---------------------------------------------------------------------------
  // Capture stage: the region test is made here and a beat that falls outside
  // the region is taken but never enters the pipeline.
  // ---------------------------------------------------------------------------
  logic [COORD_W-1:0] in_dx;
  logic [COORD_W-1:0] in_dy;
  logic               in_inside;
  logic [COORD_W-1:0] s0_dx;
  logic [COORD_W-1:0] s0_dy;
  logic [COORD_W-1:0] s0_px;

  assign in_dx     = s_tdata[COORD_W-1:0];
  assign in_dy     = s_tdata[2*COORD_W-1:COORD_W];
  assign in_inside = !cfg_empty
                     && (CMPW'(in_dx) < CMPW'(cfg_dw))
                     && (CMPW'(in_dy) < CMPW'(cfg_ph));

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_dx <= in_dx;
      s0_dy <= in_dy;
      s0_px <= COORD_W'(cfg_start + {1'b0, in_dx});
    end
  end

  // ---------------------------------------------------------------------------
  // Two restoring dividers side by side: column (dx*sw / dw) and row
  // (dy*sh / ph). The first divider stage holds the products; because the
  // quotient is below 2**QW, the product shifted down by QW bits is already a
  // valid partial remainder, and each later stage brings in one more product
  // bit and decides one quotient bit. Since dx < dw and dy < ph, each quotient
  // stays below its source dimension and needs no clamp to the last column or row.
  // ---------------------------------------------------------------------------
  logic [PDW-1:0]     xr  [0:QW];
  logic [QW-1:0]      xn  [0:QW];
  logic [QW-1:0]      xq  [0:QW];
  logic [PDW-1:0]     yr  [0:QW];
  logic [QW-1:0]      yn  [0:QW];
  logic [QW-1:0]      yq  [0:QW];
  logic [COORD_W-1:0] dpx [0:QW];
  logic [COORD_W-1:0] dpy [0:QW];

  logic [NW-1:0]      prod_x;
  logic [NW-1:0]      prod_y;

  assign prod_x = NW'(s0_dx) * NW'(cfg_sw);
  assign prod_y = NW'(s0_dy) * NW'(cfg_sh);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      xr[0]  <= PDW'(prod_x >> QW);
      xn[0]  <= prod_x[QW-1:0];
      xq[0]  <= '0;
      yr[0]  <= PDW'(prod_y >> QW);
      yn[0]  <= prod_y[QW-1:0];
      yq[0]  <= '0;
      dpx[0] <= s0_px;
      dpy[0] <= s0_dy;
    end
  end

  for (genvar j = 1; j <= QW; j++) begin : g_div
    logic [PDW:0] tx;
    logic [PDW:0] ty;
    logic         gx;
    logic         gy;

    assign tx = {xr[j-1], xn[j-1][QW-1]};
    assign ty = {yr[j-1], yn[j-1][QW-1]};
    assign gx = tx >= {1'b0, cfg_dw};
    assign gy = ty >= {1'b0, cfg_ph};

    always_ff @(posedge clk) begin
      if (en[j+1]) begin
        xr[j]  <= gx ? PDW'(tx - {1'b0, cfg_dw}) : PDW'(tx);
        xn[j]  <= xn[j-1] << 1;
        xq[j]  <= {xq[j-1][QW-2:0], gx};
        yr[j]  <= gy ? PDW'(ty - {1'b0, cfg_ph}) : PDW'(ty);
        yn[j]  <= yn[j-1] << 1;
        yq[j]  <= {yq[j-1][QW-2:0], gy};
        dpx[j] <= dpx[j-1];
        dpy[j] <= dpy[j-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pixel index sy*sw + sx, then the byte address in the output register.
  // ---------------------------------------------------------------------------
  logic [SUMW-1:0]    sa_sum;
  logic [COORD_W-1:0] sa_px;
  logic [COORD_W-1:0] sa_py;
  logic [ADDR_W-1:0]  o_addr;
  logic [COORD_W-1:0] o_px;
  logic [COORD_W-1:0] o_py;

  always_ff @(posedge clk) begin
    if (en[SA]) begin
      sa_sum <= SUMW'(yq[QW]) * SUMW'(cfg_sw) + SUMW'(xq[QW]);
      sa_px  <= dpx[QW];
      sa_py  <= dpy[QW];
    end
    if (en[OS]) begin
      o_addr <= ADDR_W'(PRODW'(sa_sum) * PRODW'(BYTES_PER_PIXEL));
      o_px   <= sa_px;
      o_py   <= sa_py;
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= s_tvalid && in_inside;
      end
      for (int i = 1; i < NST; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign m_tvalid = vld[OS];
  assign m_tdata  = {o_py, o_px, o_addr};

endmodule
